[design/pcsc_pkg.sv]
// Shared types, coefficients and helpers for the pixel color space converter.
package pcsc_pkg;

	// Component and pixel types
	typedef logic [7:0] comp_t;

	typedef struct packed {
		comp_t c3;
		comp_t c2;
		comp_t c1;
		comp_t c0;
	} pixel_t;

	// Per-stage load enables of the pipeline
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	// Source space codes
	localparam logic SRC_YUV = 1'b0;
	localparam logic SRC_RGB = 1'b1;

	// Target space codes
	localparam logic [1:0] TGT_GRAY = 2'd0;
	localparam logic [1:0] TGT_YUV  = 2'd1;
	localparam logic [1:0] TGT_RGB  = 2'd2;
	localparam logic [1:0] TGT_RGBA = 2'd3;

	// Register indexes
	localparam logic REG_SOURCE = 1'b0;
	localparam logic REG_TARGET = 1'b1;

	// YUV to RGB, 10-bit fixed point
	localparam logic signed [19:0] K_RV = 20'sd1436;
	localparam logic signed [19:0] K_GU = 20'sd352;
	localparam logic signed [19:0] K_GV = 20'sd731;
	localparam logic signed [19:0] K_BU = 20'sd1812;
	localparam logic signed [8:0]  CHROMA_OFS = 9'sd128;

	// RGB to YUV luma weights and rounding
	localparam logic [17:0] K_YR = 18'd299;
	localparam logic [17:0] K_YG = 18'd587;
	localparam logic [17:0] K_YB = 18'd114;
	localparam logic [17:0] Y_RND = 18'd500;

	// Chroma scale and offsets
	localparam logic signed [19:0] K_SCALE = 20'sd1000;
	localparam logic signed [19:0] U_OFS   = 20'sd226816;
	localparam logic signed [19:0] V_OFS   = 20'sd179456;

	// Reciprocals: floor(x / d) = (x * ceil(2^S / d)) >> S over the used ranges
	localparam int Y_SHIFT  = 28;
	localparam logic [18:0] Y_RECIP = 19'd268436;   // 1/1000, exact for x < 2^18
	localparam int UV_SHIFT = 30;
	localparam logic [19:0] U_RECIP = 20'd605950;   // 1/1772
	localparam logic [19:0] V_RECIP = 20'd765865;   // 1/1402

	// Quotient saturates at 255 from 256 * divisor upward
	localparam logic signed [19:0] U_SAT = 20'sd453632;
	localparam logic signed [19:0] V_SAT = 20'sd358912;

	localparam comp_t COMP_MAX = 8'd255;

	// Clamp a small signed sum to 0..255
	function automatic comp_t clamp8(input logic signed [11:0] v);
		comp_t r;
		if (v < 12'sd0)
			r = 8'd0;
		else if (v > 12'sd255)
			r = COMP_MAX;
		else
			r = v[7:0];
		return r;
	endfunction

endpackage

[design/pixel_color_space_convert.sv]
// Throughput: one pixel per clock while the output is not stalled; a stalled output holds
// stage 4 and the full stages directly behind it, while empty stages still load. The depth is set
// by the RGB to YUV path: luma sum, luma divide, chroma numerators, chroma divide, one per stage.
// Reset clears all stage valid bits and sets source YUV, target RGB.
// Configuration writes are taken in any cycle (cfg_ready is always high).
module pixel_color_space_convert
	import pcsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [1:0]  cfg_data,
	// Input pixel stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,    // comp0 [7:0], comp1 [15:8], comp2 [23:16], comp3 [31:24]
	// Output pixel stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata     // out0 [7:0], out1 [15:8], out2 [23:16], out3 [31:24]
);

	typedef enum logic [2:0] {
		M_PASS,
		M_GRAY,
		M_YUV_RGB,
		M_YUV_RGBA,
		M_RGB_YUV,
		M_RGB_RGBA
	} mode_t;

	logic       source_q;
	logic [1:0] target_q;
	mode_t      mode_in;
	mode_t      mode_s1;
	mode_t      mode_s2;
	mode_t      mode_s3;
	pixel_t     pix_in;
	pixel_t     pix_s1;
	pixel_t     res_s2;
	pixel_t     res_s3;
	pixel_t     out_s4;
	logic       valid_s1;
	logic       valid_s2;
	logic       valid_s3;
	logic       valid_s4;
	stage_en_t  en;
	comp_t      cv_r;
	comp_t      cv_g;
	comp_t      cv_b;
	comp_t      cv_y;
	comp_t      cv_u;
	comp_t      cv_v;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_q <= SRC_YUV;
			target_q <= TGT_RGB;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SOURCE: source_q <= cfg_data[0];
				REG_TARGET: target_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Conversion mode decode
	always_comb begin
		mode_in = M_PASS;
		if (source_q == SRC_YUV) begin
			unique case (target_q)
				TGT_YUV:  mode_in = M_PASS;
				TGT_GRAY: mode_in = M_GRAY;
				TGT_RGB:  mode_in = M_YUV_RGB;
				TGT_RGBA: mode_in = M_YUV_RGBA;
				default:  mode_in = M_PASS;
			endcase
		end else begin
			unique case (target_q) inside
				TGT_RGB:  mode_in = M_PASS;
				TGT_RGBA: mode_in = M_RGB_RGBA;
				TGT_GRAY,
				TGT_YUV:  mode_in = M_RGB_YUV;
				default:  mode_in = M_PASS;
			endcase
		end
	end

	// Stage load enables: a stage loads when empty or when its successor loads
	assign en.s4 = !valid_s4 || m_axis_tready;
	assign en.s3 = !valid_s3 || en.s4;
	assign en.s2 = !valid_s2 || en.s3;
	assign en.s1 = !valid_s1 || en.s2;
	assign s_axis_tready = en.s1;

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= s_axis_tvalid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
		end
	end

	assign pix_in = pixel_t'(s_axis_tdata);

	// Conversion datapaths
	pcsc_yuv_rgb u_yuv_rgb (
		.clk   (clk),
		.en_s1 (en.s1),
		.y     (pix_in.c0),
		.u     (pix_in.c1),
		.v     (pix_in.c2),
		.r     (cv_r),
		.g     (cv_g),
		.b     (cv_b)
	);

	pcsc_rgb_yuv u_rgb_yuv (
		.clk (clk),
		.en  (en),
		.r   (pix_in.c0),
		.g   (pix_in.c1),
		.b   (pix_in.c2),
		.y   (cv_y),
		.u   (cv_u),
		.v   (cv_v)
	);

	// Stage 1: input word and mode
	always_ff @(posedge clk) begin
		if (en.s1) begin
			pix_s1  <= pix_in;
			mode_s1 <= mode_in;
		end
	end

	// Stage 2: results of all modes but RGB to YUV
	always_ff @(posedge clk) begin
		if (en.s2) begin
			mode_s2 <= mode_s1;
			case (mode_s1)
				M_PASS:     res_s2 <= pix_s1;
				M_GRAY:     res_s2 <= '{c3: 8'd0, c2: 8'd0, c1: 8'd0, c0: pix_s1.c0};
				M_YUV_RGB:  res_s2 <= '{c3: 8'd0, c2: cv_b, c1: cv_g, c0: cv_r};
				M_YUV_RGBA: res_s2 <= '{c3: COMP_MAX, c2: cv_b, c1: cv_g, c0: cv_r};
				M_RGB_RGBA: res_s2 <= '{c3: COMP_MAX, c2: pix_s1.c2, c1: pix_s1.c1,
					c0: pix_s1.c0};
				default:    res_s2 <= '0;
			endcase
		end
	end

	// Stage 3: carry
	always_ff @(posedge clk) begin
		if (en.s3) begin
			mode_s3 <= mode_s2;
			res_s3  <= res_s2;
		end
	end

	// Stage 4: output word
	always_ff @(posedge clk) begin
		if (en.s4) begin
			if (mode_s3 == M_RGB_YUV)
				out_s4 <= '{c3: 8'd0, c2: cv_v, c1: cv_u, c0: cv_y};
			else
				out_s4 <= res_s3;
		end
	end

	assign m_axis_tvalid = valid_s4;
	assign m_axis_tdata  = out_s4;

	// A free output lets the whole pipeline advance
	a_free_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
		else $error("input stalled while the output is free");

	// A full, stalled pipeline takes no new word
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && m_axis_tvalid && !m_axis_tready)
		|-> !s_axis_tready)
		else $error("word accepted into a full stalled pipeline");

	// RGB to YUV results carry zero alpha
	a_yuv_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && en.s4 && mode_s3 == M_RGB_YUV) |=> (m_axis_tdata[31:24] == 8'd0))
		else $error("nonzero alpha on RGB to YUV result");

endmodule

[design/pcsc_yuv_rgb.sv]
// YUV to RGB datapath: coefficient products in stage 1, shift, add and clamp after.
module pcsc_yuv_rgb
	import pcsc_pkg::*;
(
	input  logic  clk,
	input  logic  en_s1,
	input  comp_t y,
	input  comp_t u,
	input  comp_t v,
	output comp_t r,
	output comp_t g,
	output comp_t b
);

	logic signed [8:0]  du;
	logic signed [8:0]  dv;
	logic signed [19:0] pr_s1;
	logic signed [19:0] pg_s1;
	logic signed [19:0] pb_s1;
	comp_t              y_s1;
	logic signed [11:0] r_sum;
	logic signed [11:0] g_sum;
	logic signed [11:0] b_sum;

	// Centered chroma
	assign du = $signed({1'b0, u}) - CHROMA_OFS;
	assign dv = $signed({1'b0, v}) - CHROMA_OFS;

	// Stage 1: constant products
	always_ff @(posedge clk) begin
		if (en_s1) begin
			pr_s1 <= 20'(dv) * K_RV;
			pg_s1 <= 20'(du) * K_GU + 20'(dv) * K_GV;
			pb_s1 <= 20'(du) * K_BU;
			y_s1  <= y;
		end
	end

	// Floor shift by 10, add to luma, clamp
	assign r_sum = $signed({4'b0, y_s1}) + 12'(pr_s1 >>> 10);
	assign g_sum = $signed({4'b0, y_s1}) - 12'(pg_s1 >>> 10);
	assign b_sum = $signed({4'b0, y_s1}) + 12'(pb_s1 >>> 10);

	assign r = clamp8(r_sum);
	assign g = clamp8(g_sum);
	assign b = clamp8(b_sum);

endmodule

[design/pcsc_rgb_yuv.sv]
// RGB to YUV datapath: luma sum, luma divide, chroma numerators, chroma divide.
module pcsc_rgb_yuv
	import pcsc_pkg::*;
(
	input  logic      clk,
	input  stage_en_t en,
	input  comp_t     r,
	input  comp_t     g,
	input  comp_t     b,
	output comp_t     y,
	output comp_t     u,
	output comp_t     v
);

	logic [17:0]        sum_s1;
	comp_t              r_s1;
	comp_t              b_s1;
	logic [36:0]        y_prod;
	comp_t              y_s2;
	comp_t              r_s2;
	comp_t              b_s2;
	logic signed [8:0]  du;
	logic signed [8:0]  dv;
	logic signed [19:0] nu_s3;
	logic signed [19:0] nv_s3;
	comp_t              y_s3;
	logic [38:0]        u_prod;
	logic [38:0]        v_prod;

	// Stage 1: weighted luma sum with rounding
	always_ff @(posedge clk) begin
		if (en.s1) begin
			sum_s1 <= 18'(r) * K_YR + 18'(g) * K_YG + 18'(b) * K_YB + Y_RND;
			r_s1   <= r;
			b_s1   <= b;
		end
	end

	// Stage 2: divide by 1000 through the reciprocal
	assign y_prod = 37'(sum_s1) * 37'(Y_RECIP);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			y_s2 <= y_prod[Y_SHIFT +: 8];
			r_s2 <= r_s1;
			b_s2 <= b_s1;
		end
	end

	// Stage 3: chroma numerators
	assign du = $signed({1'b0, b_s2}) - $signed({1'b0, y_s2});
	assign dv = $signed({1'b0, r_s2}) - $signed({1'b0, y_s2});

	always_ff @(posedge clk) begin
		if (en.s3) begin
			nu_s3 <= 20'(du) * K_SCALE + U_OFS;
			nv_s3 <= 20'(dv) * K_SCALE + V_OFS;
			y_s3  <= y_s2;
		end
	end

	// Chroma divide with saturation to 0..255
	assign u_prod = 39'(nu_s3[18:0]) * 39'(U_RECIP);
	assign v_prod = 39'(nv_s3[18:0]) * 39'(V_RECIP);

	always_comb begin
		if (nu_s3 <= 20'sd0)
			u = 8'd0;
		else if (nu_s3 >= U_SAT)
			u = COMP_MAX;
		else
			u = u_prod[UV_SHIFT +: 8];

		if (nv_s3 <= 20'sd0)
			v = 8'd0;
		else if (nv_s3 >= V_SAT)
			v = COMP_MAX;
		else
			v = v_prod[UV_SHIFT +: 8];
	end

	assign y = y_s3;

endmodule
